/* rtl/awbd_pkg.sv */
// Shared constants and types for the alpha weighted box downsampler.
`default_nettype none
package awbd_pkg;

    localparam int PIX_W              = 8;
    localparam int ALPHA_W            = 14;
    localparam int COLOR_W            = 22;
    localparam int SUM_W              = ALPHA_W + 3 * COLOR_W;
    localparam int SCALE_CFG_W        = 4;
    localparam int WIDTH_CFG_W        = 9;
    localparam int DEF_MAX_DST_WIDTH  = 256;
    localparam int DEF_MAX_SCALE      = 8;
    localparam int SCALE_RESET        = 2;
    localparam int WIDTH_RESET        = 16;
    localparam int APB_ADDR_W         = 3;
    localparam int APB_DATA_W         = 32;
    localparam int DIV_CNT_W          = $clog2(COLOR_W + 1);

    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_WIDTH = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage
`default_nettype wire

/* rtl/awbd_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module awbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/awbd_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module awbd_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [awbd_pkg::COLOR_W-1:0]  i_dividend,
    input  wire logic [awbd_pkg::ALPHA_W-1:0]  i_divisor,
    output awbd_pkg::t_div_status              o_status,
    output logic      [awbd_pkg::PIX_W-1:0]    o_quotient
);
    import awbd_pkg::*;

    logic [COLOR_W-1:0]   r_quo;
    logic [ALPHA_W-1:0]   r_rem;
    logic [ALPHA_W-1:0]   r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [ALPHA_W:0]     shifted;
    logic [ALPHA_W:0]     trial;
    logic                 take;

    assign shifted = {r_rem, r_quo[COLOR_W-1]};
    assign trial   = shifted - {1'b0, r_div};
    assign take    = (shifted >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(COLOR_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? trial[ALPHA_W-1:0] : shifted[ALPHA_W-1:0];
            r_quo <= {r_quo[COLOR_W-2:0], take};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo[PIX_W-1:0];

endmodule
`default_nettype wire

/* rtl/alpha_weighted_box_downsample.sv */
// Top level of the alpha weighted box downsampler with its sequencer and register port.
// A pixel that does not close a block passes through the transfer and the accumulate.
// A pixel that closes a block passes through the transfer, the accumulate, four 22-step
// divisions on the shared bit-serial divider, then the output load, which waits while the
// previous output pixel is still held. Reset is synchronous, active low, and clears the
// registers, counters, sequencer and output valid, not the sum memory.
`default_nettype none
module alpha_weighted_box_downsample #(
    parameter int MAX_DST_WIDTH = awbd_pkg::DEF_MAX_DST_WIDTH,
    parameter int MAX_SCALE     = awbd_pkg::DEF_MAX_SCALE
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // tdata: src_red, src_green, src_blue, src_alpha
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [4*awbd_pkg::PIX_W-1:0]     i_s_tdata,
    // tdata: out_red, out_green, out_blue, out_alpha
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic      [4*awbd_pkg::PIX_W-1:0]     o_m_tdata,
    output logic                                  o_m_tlast,
    // tuser: end_of_frame
    output logic                                  o_m_tuser,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [awbd_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [awbd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [awbd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);
    import awbd_pkg::*;

    localparam int XW  = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
    localparam int SW  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int WW  = $clog2(MAX_DST_WIDTH + 1);
    localparam int SSW = $clog2(MAX_SCALE + 1);
    localparam int SQW = 2 * SSW;

    localparam logic [1:0] DIV_ALPHA = 2'd0;
    localparam logic [1:0] DIV_RED   = 2'd1;
    localparam logic [1:0] DIV_GREEN = 2'd2;
    localparam logic [1:0] DIV_BLUE  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [SCALE_CFG_W-1:0] r_scale_cfg;
    logic [WIDTH_CFG_W-1:0] r_width_cfg;
    logic [SW-1:0]          r_sx;
    logic [SW-1:0]          r_row;
    logic [XW-1:0]          r_x;
    logic [XW-1:0]          r_orow;
    logic [1:0]             r_div_idx;
    logic                   r_out_valid;

    logic [PIX_W-1:0]       r_pr, r_pg, r_pb, r_pa;
    logic [ALPHA_W-1:0]     r_sum_a;
    logic [COLOR_W-1:0]     r_sum_r, r_sum_g, r_sum_b;
    logic [PIX_W-1:0]       r_q_r, r_q_g, r_q_b, r_q_a;
    logic                   r_eor, r_eof;
    logic [4*PIX_W-1:0]     r_out_data;
    logic                   r_out_last, r_out_user;

    logic [SSW-1:0]         eff_s;
    logic [WW-1:0]          eff_w;
    logic [SW-1:0]          s_m1;
    logic [XW-1:0]          w_m1;
    logic [SQW-1:0]         s_sq;
    logic                   cfg_wr;
    logic                   in_xfer;
    logic                   first_px;
    logic                   last_px;
    logic                   load_out;
    logic [SUM_W-1:0]       rd_data;
    logic [2*PIX_W-1:0]     prod_r, prod_g, prod_b;
    logic [ALPHA_W-1:0]     n_sum_a;
    logic [COLOR_W-1:0]     n_sum_r, n_sum_g, n_sum_b;
    logic [COLOR_W-1:0]     div_dividend;
    logic [ALPHA_W-1:0]     div_divisor;
    logic                   div_start;
    t_div_status            div_st;
    logic [PIX_W-1:0]       div_quo;
    logic                   opaque;

    always_comb begin
        if (r_scale_cfg == '0) begin
            eff_s = SSW'(1);
        end else if (32'(r_scale_cfg) > MAX_SCALE) begin
            eff_s = SSW'(MAX_SCALE);
        end else begin
            eff_s = SSW'(r_scale_cfg);
        end
        if (r_width_cfg == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_width_cfg) > MAX_DST_WIDTH) begin
            eff_w = WW'(MAX_DST_WIDTH);
        end else begin
            eff_w = WW'(r_width_cfg);
        end
    end

    assign s_m1 = SW'(eff_s - 1'b1);
    assign w_m1 = XW'(eff_w - 1'b1);
    assign s_sq = SQW'(eff_s) * SQW'(eff_s);

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            REG_SCALE: prdata = APB_DATA_W'(r_scale_cfg);
            REG_WIDTH: prdata = APB_DATA_W'(r_width_cfg);
            default:   prdata = '0;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign first_px   = (r_row == '0) && (r_sx == '0);
    assign last_px    = (r_row == s_m1) && (r_sx == s_m1);
    assign load_out   = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);
    assign div_start  = (r_state == S_DIV_GO);
    assign opaque     = (r_sum_a != '0);

    assign prod_r = r_pr * r_pa;
    assign prod_g = r_pg * r_pa;
    assign prod_b = r_pb * r_pa;

    always_comb begin
        if (first_px) begin
            n_sum_a = ALPHA_W'(r_pa);
            n_sum_r = COLOR_W'(prod_r);
            n_sum_g = COLOR_W'(prod_g);
            n_sum_b = COLOR_W'(prod_b);
        end else begin
            n_sum_a = rd_data[ALPHA_W-1:0] + ALPHA_W'(r_pa);
            n_sum_r = rd_data[ALPHA_W +: COLOR_W] + COLOR_W'(prod_r);
            n_sum_g = rd_data[ALPHA_W+COLOR_W +: COLOR_W] + COLOR_W'(prod_g);
            n_sum_b = rd_data[ALPHA_W+2*COLOR_W +: COLOR_W] + COLOR_W'(prod_b);
        end
    end

    awbd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_DST_WIDTH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (r_state == S_ACC),
        .i_waddr (r_x),
        .i_wdata ({n_sum_b, n_sum_g, n_sum_r, n_sum_a}),
        .i_raddr (r_x),
        .o_rdata (rd_data)
    );

    always_comb begin
        case (r_div_idx)
            DIV_ALPHA: begin
                div_dividend = COLOR_W'(r_sum_a);
                div_divisor  = ALPHA_W'(s_sq);
            end
            DIV_RED: begin
                div_dividend = r_sum_r;
                div_divisor  = r_sum_a;
            end
            DIV_GREEN: begin
                div_dividend = r_sum_g;
                div_divisor  = r_sum_a;
            end
            DIV_BLUE: begin
                div_dividend = r_sum_b;
                div_divisor  = r_sum_a;
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    awbd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_status   (div_st),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scale_cfg <= SCALE_CFG_W'(SCALE_RESET);
            r_width_cfg <= WIDTH_CFG_W'(WIDTH_RESET);
            r_sx        <= '0;
            r_row       <= '0;
            r_x         <= '0;
            r_orow      <= '0;
            r_div_idx   <= DIV_ALPHA;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                case (paddr[2])
                    REG_SCALE: r_scale_cfg <= pwdata[SCALE_CFG_W-1:0];
                    REG_WIDTH: r_width_cfg <= pwdata[WIDTH_CFG_W-1:0];
                    default:   r_scale_cfg <= r_scale_cfg;
                endcase
                r_sx   <= '0;
                r_row  <= '0;
                r_x    <= '0;
                r_orow <= '0;
            end else if (r_state == S_ACC) begin
                if (r_sx == s_m1) begin
                    r_sx <= '0;
                    if (r_x == w_m1) begin
                        r_x <= '0;
                        if (r_row == s_m1) begin
                            r_row  <= '0;
                            r_orow <= (r_orow == w_m1) ? '0 : r_orow + 1'b1;
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end else begin
                    r_sx <= r_sx + 1'b1;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_div_idx <= DIV_ALPHA;
                    r_state   <= last_px ? S_DIV_GO : S_IDLE;
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_st.done) begin
                        r_div_idx <= r_div_idx + 1'b1;
                        r_state   <= (r_div_idx == DIV_BLUE) ? S_EMIT : S_DIV_GO;
                    end
                end
                S_EMIT: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pr <= i_s_tdata[0*PIX_W +: PIX_W];
            r_pg <= i_s_tdata[1*PIX_W +: PIX_W];
            r_pb <= i_s_tdata[2*PIX_W +: PIX_W];
            r_pa <= i_s_tdata[3*PIX_W +: PIX_W];
        end
        if (r_state == S_ACC) begin
            r_sum_a <= n_sum_a;
            r_sum_r <= n_sum_r;
            r_sum_g <= n_sum_g;
            r_sum_b <= n_sum_b;
            r_eor   <= (r_x == w_m1);
            r_eof   <= (r_x == w_m1) && (r_orow == w_m1);
        end
        if (r_state == S_DIV_WAIT && div_st.done) begin
            case (r_div_idx)
                DIV_ALPHA: r_q_a <= div_quo;
                DIV_RED:   r_q_r <= div_quo;
                DIV_GREEN: r_q_g <= div_quo;
                DIV_BLUE:  r_q_b <= div_quo;
                default:   r_q_a <= r_q_a;
            endcase
        end
        if (load_out) begin
            r_out_data <= {r_q_a,
                           opaque ? r_q_b : '0,
                           opaque ? r_q_g : '0,
                           opaque ? r_q_r : '0};
            r_out_last <= r_eor;
            r_out_user <= r_eof;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

    a_counters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sx <= s_m1) && (r_row <= s_m1) && (r_x <= w_m1) && (r_orow <= w_m1))
        else $error("block counters outside the configured geometry");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_st.done || div_st.busy) |-> (r_state == S_DIV_WAIT))
        else $error("divider active outside the wait state");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !i_m_tready) |=>
            (r_state == S_EMIT) && r_out_valid)
        else $error("pending output pixel was overwritten");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_ACC) && !o_s_tready)
        else $error("pixel transfer not followed by accumulation");

endmodule
`default_nettype wire
